FILE: rtl/core/hsp_pkg.sv
// Shared widths, register indexes and the configuration struct of the strip partitioner.
package hsp_pkg;

    localparam int ROW_W    = 16;
    localparam int HALO_W   = 7;
    localparam int STRIDE_W = 16;
    localparam int BYTES_W  = 32;
    localparam int PACK_W   = 40;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_IMAGE_ROWS = 2'd0;
    localparam logic [1:0] REG_HALO_ROWS  = 2'd1;
    localparam logic [1:0] REG_STRIDE     = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0]    image_rows;
        logic [HALO_W-1:0]   halo_rows;
        logic [STRIDE_W-1:0] row_pitch;
    } cfg_t;

endpackage

FILE: rtl/core/halo_strip_partitioner_unit.sv
// Strip partitioner top level: command port, part sequencer and shared stride multiplier.
//
// Pulse start while busy is low to split the image into part_count strips (0 means one,
// counts above MAX_PARTS saturate). The block divides the row count by the part count in
// a one-bit-per-cycle divider, then walks the parts in order; each part passes a row
// figure step (ST_ROWS) and four steps (ST_MUL0-ST_MUL3) on a single 16x16 multiplier
// that scales them by the row stride. No new item is taken until the last part is out.
// Each result is shown for exactly one cycle with strobe high and must be taken then; the
// receiver cannot stall it. last marks the final part. busy drops in the cycle that shows
// the final result, so the next item may be started then. Configure the registers only
// while busy is low.
module halo_strip_partitioner_unit #(
    parameter int MAX_PARTS = 64,
    parameter int ROW_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsp_pkg::DATA_W-1:0]  pwdata,
    output logic [hsp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        start,
    input  logic [hsp_pkg::COUNT_W-1:0] part_count,
    output logic                        busy,
    output logic                        strobe,
    output logic [hsp_pkg::INDEX_W-1:0] part_index,
    output logic [hsp_pkg::ROW_W-1:0]   own_start_row,
    output logic [hsp_pkg::ROW_W-1:0]   own_rows,
    output logic [hsp_pkg::ROW_W-1:0]   send_start_row,
    output logic [hsp_pkg::ROW_W-1:0]   send_row_count,
    output logic [hsp_pkg::BYTES_W-1:0] send_bytes,
    output logic [hsp_pkg::BYTES_W-1:0] source_offset_bytes,
    output logic [hsp_pkg::BYTES_W-1:0] recv_bytes,
    output logic [hsp_pkg::BYTES_W-1:0] recv_offset_bytes,
    output logic [hsp_pkg::PACK_W-1:0]  packed_offset_bytes,
    output logic                        last
);
    import hsp_pkg::*;

    localparam int PW = (MAX_PARTS >= 127) ? COUNT_W : $clog2(MAX_PARTS + 1);
    localparam logic [ROW_W-1:0] ROW_MASK =
        (ROW_BITS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((32'd1 << ROW_BITS) - 32'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ROWS = 3'd2;
    localparam logic [2:0] ST_MUL0 = 3'd3;
    localparam logic [2:0] ST_MUL1 = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_MUL3 = 3'd6;

    cfg_t             cfg;
    logic [ROW_W-1:0] h;
    logic             accept;
    logic [8:0]       req_parts;
    logic [8:0]       sat_parts;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [PW-1:0]    parts_reg;
    logic [PW-1:0]    idx_reg;
    logic [ROW_W-1:0] q_reg;
    logic [PW-1:0]    r_reg;
    logic [ROW_W-1:0] start_acc_reg;
    logic [ROW_W-1:0] start_w_reg;
    logic [ROW_W-1:0] num_w_reg;
    logic [ROW_W-1:0] sstart_w_reg;
    logic [ROW_W-1:0] srows_w_reg;
    logic [BYTES_W-1:0] sbytes_w_reg;
    logic [BYTES_W-1:0] soff_w_reg;
    logic [BYTES_W-1:0] rbytes_w_reg;
    logic [PACK_W-1:0]  running_reg;

    logic             div_done;
    logic [ROW_W-1:0] div_quo;
    logic [PW-1:0]    div_rem;
    logic             part_last;

    logic [ROW_W-1:0] num_c;
    logic [ROW_W-1:0] sstart_c;
    logic [ROW_W+1:0] send_wide;
    logic [ROW_W-1:0] send_c;
    logic [ROW_W-1:0] srows_c;
    logic [ROW_W-1:0] mul_a;
    logic [BYTES_W-1:0] mul_prod;

    logic               strobe_reg;
    logic [INDEX_W-1:0] part_index_reg;
    logic [ROW_W-1:0]   own_start_reg;
    logic [ROW_W-1:0]   own_rows_reg;
    logic [ROW_W-1:0]   send_start_reg;
    logic [ROW_W-1:0]   send_row_count_reg;
    logic [BYTES_W-1:0] send_bytes_reg;
    logic [BYTES_W-1:0] src_off_reg;
    logic [BYTES_W-1:0] recv_bytes_reg;
    logic [BYTES_W-1:0] recv_off_reg;
    logic [PACK_W-1:0]  packed_reg;
    logic               last_reg;

    hsp_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign h      = cfg.image_rows & ROW_MASK;
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Zero parts means one; clip at the configured maximum.
    always_comb
    begin
        req_parts = (part_count == '0) ? 9'd1 : {2'b00, part_count};
        sat_parts = (req_parts > 9'(MAX_PARTS)) ? 9'(MAX_PARTS) : req_parts;
    end

    hsp_divider #(
        .DIV_W (PW)
    ) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .dividend  (h),
        .divisor   (PW'(sat_parts)),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign part_last = (idx_reg == parts_reg - PW'(1));

    // Row figures of the current part; its start is the sum of the earlier strips.
    always_comb
    begin
        num_c     = q_reg + ((idx_reg < r_reg) ? ROW_W'(1) : ROW_W'(0));
        sstart_c  = (start_acc_reg > {{(ROW_W-HALO_W){1'b0}}, cfg.halo_rows})
                    ? start_acc_reg - {{(ROW_W-HALO_W){1'b0}}, cfg.halo_rows}
                    : '0;
        send_wide = {2'b00, start_acc_reg} + {2'b00, num_c}
                    + {{(ROW_W+2-HALO_W){1'b0}}, cfg.halo_rows};
        send_c    = (send_wide > {2'b00, h}) ? h : send_wide[ROW_W-1:0];
        srows_c   = (sstart_c < send_c) ? send_c - sstart_c : '0;
    end

    // One shared multiplier; the state picks the row figure to scale.
    always_comb
    begin
        unique case (state_reg)
            ST_MUL0: mul_a = srows_w_reg;
            ST_MUL1: mul_a = sstart_w_reg;
            ST_MUL2: mul_a = num_w_reg;
            ST_MUL3: mul_a = start_w_reg;
            default: mul_a = '0;
        endcase
        mul_prod = {{(BYTES_W-ROW_W){1'b0}}, mul_a}
                 * {{(BYTES_W-STRIDE_W){1'b0}}, cfg.row_pitch};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_ROWS;
            ST_ROWS: state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = part_last ? ST_IDLE : ST_ROWS;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            strobe_reg    <= 1'b0;
            parts_reg     <= '0;
            idx_reg       <= '0;
            q_reg         <= '0;
            r_reg         <= '0;
            start_acc_reg <= '0;
            running_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_MUL3);
            if (accept)
            begin
                parts_reg     <= PW'(sat_parts);
                idx_reg       <= '0;
                start_acc_reg <= '0;
                running_reg   <= '0;
            end
            if (state_reg == ST_DIV && div_done)
            begin
                q_reg <= div_quo;
                r_reg <= div_rem;
            end
            if (state_reg == ST_ROWS)
            begin
                start_acc_reg <= start_acc_reg + num_c;
            end
            if (state_reg == ST_MUL3)
            begin
                idx_reg     <= idx_reg + PW'(1);
                running_reg <= running_reg + {{(PACK_W-BYTES_W){1'b0}}, sbytes_w_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_ROWS:
            begin
                start_w_reg  <= start_acc_reg;
                num_w_reg    <= num_c;
                sstart_w_reg <= sstart_c;
                srows_w_reg  <= srows_c;
            end
            ST_MUL0: sbytes_w_reg <= mul_prod;
            ST_MUL1: soff_w_reg   <= mul_prod;
            ST_MUL2: rbytes_w_reg <= mul_prod;
            ST_MUL3:
            begin
                part_index_reg     <= INDEX_W'(idx_reg);
                own_start_reg      <= start_w_reg;
                own_rows_reg       <= num_w_reg;
                send_start_reg     <= sstart_w_reg;
                send_row_count_reg <= srows_w_reg;
                send_bytes_reg     <= sbytes_w_reg;
                src_off_reg        <= soff_w_reg;
                recv_bytes_reg     <= rbytes_w_reg;
                recv_off_reg       <= mul_prod;
                packed_reg         <= running_reg;
                last_reg           <= part_last;
            end
            default: ;
        endcase
    end

    assign strobe              = strobe_reg;
    assign part_index          = part_index_reg;
    assign own_start_row       = own_start_reg;
    assign own_rows            = own_rows_reg;
    assign send_start_row      = send_start_reg;
    assign send_row_count      = send_row_count_reg;
    assign send_bytes          = send_bytes_reg;
    assign source_offset_bytes = src_off_reg;
    assign recv_bytes          = recv_bytes_reg;
    assign recv_offset_bytes   = recv_off_reg;
    assign packed_offset_bytes = packed_reg;
    assign last                = last_reg;

    a_strobe_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg) == ST_MUL3)
        else $error("result strobe without a finished multiply pass");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("still busy after the final part");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROWS) |-> (idx_reg < parts_reg))
        else $error("part index ran past the part count");

endmodule

FILE: rtl/core/hsp_apb_regs.sv
// APB configuration registers: image rows, halo rows and row stride.
module hsp_apb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hsp_pkg::ADDR_W-1:0] paddr,
    input  logic [hsp_pkg::DATA_W-1:0] pwdata,
    output logic [hsp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output hsp_pkg::cfg_t              cfg
);
    import hsp_pkg::*;

    logic [ROW_W-1:0]    image_rows_reg;
    logic [HALO_W-1:0]   halo_rows_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg <= '0;
            halo_rows_reg  <= '0;
            stride_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_ROWS: image_rows_reg <= pwdata[ROW_W-1:0];
                REG_HALO_ROWS:  halo_rows_reg  <= pwdata[HALO_W-1:0];
                REG_STRIDE:     stride_reg     <= pwdata[STRIDE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_ROWS: prdata = {{(DATA_W-ROW_W){1'b0}}, image_rows_reg};
            REG_HALO_ROWS:  prdata = {{(DATA_W-HALO_W){1'b0}}, halo_rows_reg};
            REG_STRIDE:     prdata = {{(DATA_W-STRIDE_W){1'b0}}, stride_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.image_rows = image_rows_reg;
    assign cfg.halo_rows  = halo_rows_reg;
    assign cfg.row_pitch  = stride_reg;

endmodule

FILE: rtl/core/hsp_divider.sv
// Restoring divider: row count by part count, one quotient bit per cycle.
module hsp_divider #(
    parameter int DIV_W = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [hsp_pkg::ROW_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [hsp_pkg::ROW_W-1:0] quotient,
    output logic [DIV_W-1:0]          remainder
);
    import hsp_pkg::*;

    localparam int CNT_W = $clog2(ROW_W + 1);

    logic [ROW_W-1:0] quo_reg;
    logic [ROW_W-1:0] quo_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[ROW_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_next = {quo_reg[ROW_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg  <= CNT_W'(ROW_W);
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: dv/strip_plan_checker.sv
// Checker for the strip partitioner: tracks register writes, checks read data, predicts every strip and compares.
`timescale 1ns / 1ps

module strip_plan_checker #(
    parameter int MAX_PARTS = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsp_pkg::ADDR_W-1:0]  paddr,
    input  logic [hsp_pkg::DATA_W-1:0]  pwdata,
    input  logic [hsp_pkg::DATA_W-1:0]  prdata,
    input  logic                        pready,
    input  logic                        start,
    input  logic [hsp_pkg::COUNT_W-1:0] part_count,
    input  logic                        busy,
    input  logic                        strobe,
    input  logic [hsp_pkg::INDEX_W-1:0] part_index,
    input  logic [hsp_pkg::ROW_W-1:0]   own_start_row,
    input  logic [hsp_pkg::ROW_W-1:0]   own_rows,
    input  logic [hsp_pkg::ROW_W-1:0]   send_start_row,
    input  logic [hsp_pkg::ROW_W-1:0]   send_row_count,
    input  logic [hsp_pkg::BYTES_W-1:0] send_bytes,
    input  logic [hsp_pkg::BYTES_W-1:0] source_offset_bytes,
    input  logic [hsp_pkg::BYTES_W-1:0] recv_bytes,
    input  logic [hsp_pkg::BYTES_W-1:0] recv_offset_bytes,
    input  logic [hsp_pkg::PACK_W-1:0]  packed_offset_bytes,
    input  logic                        last,
    output int                          errors,
    output int                          outstanding
);

    import hsp_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] part_index;
        logic [ROW_W-1:0]   own_start_row;
        logic [ROW_W-1:0]   own_rows;
        logic [ROW_W-1:0]   send_start_row;
        logic [ROW_W-1:0]   send_row_count;
        logic [BYTES_W-1:0] send_bytes;
        logic [BYTES_W-1:0] source_offset_bytes;
        logic [BYTES_W-1:0] recv_bytes;
        logic [BYTES_W-1:0] recv_offset_bytes;
        logic [PACK_W-1:0]  packed_offset_bytes;
        logic               last;
    } strip_t;

    cfg_t   cfg;
    strip_t expected_strips[$];

    // Split the configured image into strips and queue one expected result per part.
    task automatic plan_strips(input logic [COUNT_W-1:0] count);
        longint unsigned parts;
        longint unsigned rows;
        longint unsigned halo;
        longint unsigned stride;
        longint unsigned quot;
        longint unsigned rem;
        longint unsigned first;
        longint unsigned num;
        longint unsigned sfirst;
        longint unsigned send_limit;
        longint unsigned srows;
        longint unsigned packed_sum;
        strip_t          s;
        parts = (count == 0) ? 1 : count;
        if (parts > MAX_PARTS)
            parts = MAX_PARTS;
        rows   = cfg.image_rows;
        halo   = cfg.halo_rows;
        stride = cfg.row_pitch;
        quot   = rows / parts;
        rem    = rows % parts;
        packed_sum = 0;
        for (longint unsigned i = 0; i < parts; i++)
        begin
            first      = i * quot + ((i < rem) ? i : rem);
            num        = quot + ((i < rem) ? 1 : 0);
            sfirst     = (first > halo) ? first - halo : 0;
            send_limit = first + num + halo;
            if (send_limit > rows)
                send_limit = rows;
            srows = (sfirst < send_limit) ? send_limit - sfirst : 0;
            s.part_index          = i[INDEX_W-1:0];
            s.own_start_row       = first[ROW_W-1:0];
            s.own_rows            = num[ROW_W-1:0];
            s.send_start_row      = sfirst[ROW_W-1:0];
            s.send_row_count      = srows[ROW_W-1:0];
            s.send_bytes          = BYTES_W'(srows * stride);
            s.source_offset_bytes = BYTES_W'(sfirst * stride);
            s.recv_bytes          = BYTES_W'(num * stride);
            s.recv_offset_bytes   = BYTES_W'(first * stride);
            s.packed_offset_bytes = packed_sum[PACK_W-1:0];
            s.last                = (i + 1 == parts);
            expected_strips.push_back(s);
            packed_sum = (packed_sum + s.send_bytes) & 64'hFF_FFFF_FFFF;
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        strip_t want;
        logic [DATA_W-1:0] reg_val;
        if (!rst_n)
        begin
            cfg = '0;
            expected_strips.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (strobe)
            begin
                if (expected_strips.size() == 0)
                begin
                    $error("unexpected result for part %0d", part_index);
                    errors++;
                end
                else
                begin
                    want = expected_strips.pop_front();
                    check_field("part_index", want.part_index, part_index);
                    check_field("own_start_row", want.own_start_row, own_start_row);
                    check_field("own_rows", want.own_rows, own_rows);
                    check_field("send_start_row", want.send_start_row, send_start_row);
                    check_field("send_row_count", want.send_row_count, send_row_count);
                    check_field("send_bytes", want.send_bytes, send_bytes);
                    check_field("source_offset_bytes", want.source_offset_bytes,
                                source_offset_bytes);
                    check_field("recv_bytes", want.recv_bytes, recv_bytes);
                    check_field("recv_offset_bytes", want.recv_offset_bytes,
                                recv_offset_bytes);
                    check_field("packed_offset_bytes", want.packed_offset_bytes,
                                packed_offset_bytes);
                    check_field("last", want.last, last);
                end
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_IMAGE_ROWS: cfg.image_rows = pwdata[ROW_W-1:0];
                        REG_HALO_ROWS:  cfg.halo_rows  = pwdata[HALO_W-1:0];
                        REG_STRIDE:     cfg.row_pitch  = pwdata[STRIDE_W-1:0];
                        default: ;
                    endcase
                end
                else if (paddr[3:2] != 2'd3)
                begin
                    case (paddr[3:2])
                        REG_IMAGE_ROWS: reg_val = DATA_W'(cfg.image_rows);
                        REG_HALO_ROWS:  reg_val = DATA_W'(cfg.halo_rows);
                        default:        reg_val = DATA_W'(cfg.row_pitch);
                    endcase
                    check_field("prdata", reg_val, prdata);
                end
            end

            if (start && !busy)
                plan_strips(part_count);

            outstanding = expected_strips.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Testbench top for the strip partitioner: clock, reset, register setup, item stimulus, verdict.
`timescale 1ns / 1ps

module testbench;

    import hsp_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                start;
    logic [COUNT_W-1:0]  part_count;
    logic                busy;
    logic                strobe;
    logic [INDEX_W-1:0]  part_index;
    logic [ROW_W-1:0]    own_start_row;
    logic [ROW_W-1:0]    own_rows;
    logic [ROW_W-1:0]    send_start_row;
    logic [ROW_W-1:0]    send_row_count;
    logic [BYTES_W-1:0]  send_bytes;
    logic [BYTES_W-1:0]  source_offset_bytes;
    logic [BYTES_W-1:0]  recv_bytes;
    logic [BYTES_W-1:0]  recv_offset_bytes;
    logic [PACK_W-1:0]   packed_offset_bytes;
    logic                last;
    int                  errors;
    int                  outstanding;

    halo_strip_partitioner_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .start               (start),
        .part_count          (part_count),
        .busy                (busy),
        .strobe              (strobe),
        .part_index          (part_index),
        .own_start_row       (own_start_row),
        .own_rows            (own_rows),
        .send_start_row      (send_start_row),
        .send_row_count      (send_row_count),
        .send_bytes          (send_bytes),
        .source_offset_bytes (source_offset_bytes),
        .recv_bytes          (recv_bytes),
        .recv_offset_bytes   (recv_offset_bytes),
        .packed_offset_bytes (packed_offset_bytes),
        .last                (last)
    );

    strip_plan_checker chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .start               (start),
        .part_count          (part_count),
        .busy                (busy),
        .strobe              (strobe),
        .part_index          (part_index),
        .own_start_row       (own_start_row),
        .own_rows            (own_rows),
        .send_start_row      (send_start_row),
        .send_row_count      (send_row_count),
        .send_bytes          (send_bytes),
        .source_offset_bytes (source_offset_bytes),
        .recv_bytes          (recv_bytes),
        .recv_offset_bytes   (recv_offset_bytes),
        .packed_offset_bytes (packed_offset_bytes),
        .last                (last),
        .errors              (errors),
        .outstanding         (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drain all strips, then write and read back every register.
    task automatic set_image(input logic [15:0] rows, input logic [6:0] halo,
                             input logic [15:0] stride);
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        apb_access(1'b1, REG_IMAGE_ROWS, {16'h0, rows});
        apb_access(1'b1, REG_HALO_ROWS, {25'h0, halo});
        apb_access(1'b1, REG_STRIDE, {16'h0, stride});
        apb_access(1'b0, REG_IMAGE_ROWS, '0);
        apb_access(1'b0, REG_HALO_ROWS, '0);
        apb_access(1'b0, REG_STRIDE, '0);
    endtask

    // Hold start until the block takes the item.
    task automatic issue_item(input logic [6:0] count);
        @(negedge clk);
        start      = 1'b1;
        part_count = count;
        do @(posedge clk); while (busy);
    endtask

    initial
    begin
        logic [6:0] counts_a[9];
        logic [6:0] cnt;
        int         pick;
        bit         idle_on;

        counts_a   = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd7, 7'd63, 7'd64, 7'd65, 7'd127};
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        part_count = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty image
        issue_item(7'd0);
        issue_item(7'd5);

        set_image(16'd100, 7'd3, 16'd64);
        foreach (counts_a[k])
            issue_item(counts_a[k]);

        set_image(16'd0, 7'd5, 16'd10);
        issue_item(7'd0);
        issue_item(7'd4);

        set_image(16'hFFFF, 7'd127, 16'hFFFF);
        issue_item(7'd1);
        issue_item(7'd64);
        issue_item(7'd2);

        // more parts than rows, halo wider than the image
        set_image(16'd7, 7'd127, 16'd1);
        issue_item(7'd9);
        issue_item(7'd64);

        set_image(16'd1000, 7'd0, 16'd0);
        issue_item(7'd6);
        issue_item(7'd1);

        for (int ph = 0; ph < 8; ph++)
        begin
            logic [15:0] rows;
            logic [6:0]  halo;
            logic [15:0] stride;
            pick = $urandom_range(5);
            rows = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                   (pick == 2) ? 16'($urandom_range(1, 80)) : 16'($urandom);
            pick = $urandom_range(3);
            halo = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd127 : 7'($urandom);
            pick = $urandom_range(4);
            stride = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 :
                     (pick == 2) ? 16'hFFFF : 16'($urandom);
            set_image(rows, halo, stride);
            idle_on = (ph != 3);
            for (int n = 0; n < 45; n++)
            begin
                if (idle_on && $urandom_range(99) < 12)
                begin
                    @(negedge clk);
                    start      = 1'b0;
                    part_count = 7'($urandom);
                    repeat ($urandom_range(1, 120)) @(negedge clk);
                end
                pick = $urandom_range(99);
                if (pick < 55)
                    cnt = 7'($urandom_range(0, 16));
                else if (pick < 85)
                    cnt = 7'($urandom_range(17, 64));
                else
                    cnt = 7'($urandom_range(65, 127));
                issue_item(cnt);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
